/* hw/rtl/rc6pwd_pkg.sv */
// ----------------------------------------------------------------------------
// rc6pwd_pkg
// Shared constants, status codes and the result record of the RC6 decoder.
// ----------------------------------------------------------------------------
package rc6pwd_pkg;

	localparam int unsigned WidthBits   = 16;
	localparam int unsigned FrameBits   = 21;
	localparam int unsigned CountBits   = 5;
	localparam int unsigned UnitBits    = 3;

	localparam logic [CountBits-1:0] FRAME_LAST_BIT = 5'd20;
	localparam logic [CountBits-1:0] FRAME_TOTAL    = 5'd21;
	localparam logic [CountBits-1:0] TRAILER_INDEX  = 5'd4;

	localparam logic [UnitBits-1:0] LEN_NORMAL  = 3'd2;
	localparam logic [UnitBits-1:0] LEN_TRAILER = 3'd4;

	localparam logic [WidthBits-1:0] HALF_MIN_RESET = 16'd356;
	localparam logic [WidthBits-1:0] HALF_MAX_RESET = 16'd534;

	// Configuration register indexes.
	localparam logic CFG_HALF_MIN = 1'b0;
	localparam logic CFG_HALF_MAX = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_WIDTH = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	typedef struct packed {
		logic [7:0] address;
		logic [7:0] command;
		logic [2:0] mode;
		logic       toggle;
		logic [1:0] status;
	} result_t;

endpackage

/* hw/rtl/rc6pwd_classify.sv */
// ----------------------------------------------------------------------------
// rc6pwd_classify
// Maps a pulse width onto one, two or three half-bit units, or zero if none.
// ----------------------------------------------------------------------------
module rc6pwd_classify
	import rc6pwd_pkg::*;
(
	input  logic [WidthBits-1:0] width,
	input  logic [WidthBits-1:0] half_min,
	input  logic [WidthBits-1:0] half_max,
	output logic [1:0]           units
);

	logic [WidthBits+1:0] w_ext;
	logic [WidthBits+1:0] min1;
	logic [WidthBits+1:0] max1;
	logic [WidthBits+1:0] min2;
	logic [WidthBits+1:0] max2;
	logic [WidthBits+1:0] min3;
	logic [WidthBits+1:0] max3;

	always_comb begin
		w_ext = {2'b00, width};
		min1  = {2'b00, half_min};
		max1  = {2'b00, half_max};
		min2  = {1'b0, half_min, 1'b0};
		max2  = {1'b0, half_max, 1'b0};
		min3  = min1 + min2;
		max3  = max1 + max2;
		// Windows are tried from the narrowest up; the first match wins.
		if (w_ext >= min1 && w_ext <= max1) begin
			units = 2'd1;
		end else if (w_ext >= min2 && w_ext <= max2) begin
			units = 2'd2;
		end else if (w_ext >= min3 && w_ext <= max3) begin
			units = 2'd3;
		end else begin
			units = 2'd0;
		end
	end

endmodule

/* hw/rtl/rc6pwd_core.sv */
// ----------------------------------------------------------------------------
// rc6pwd_core
// Input register, frame state and the per-pulse Manchester unit decoding.
// ----------------------------------------------------------------------------
module rc6pwd_core
	import rc6pwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WidthBits-1:0] in_width,
	input  logic                 in_level,
	input  logic                 in_start,
	input  logic                 in_end,
	input  logic [WidthBits-1:0] half_min,
	input  logic [WidthBits-1:0] half_max,
	input  logic                 res_free,
	output logic                 res_valid,
	output result_t              res
);

	logic                 valid_s1;
	logic [WidthBits-1:0] width_s1;
	logic                 level_s1;
	logic                 start_s1;
	logic                 end_s1;

	logic [FrameBits-1:0] bits_q;
	logic [CountBits-1:0] cnt_q;
	logic [UnitBits-1:0]  hu_q;
	logic                 fhl_q;
	logic                 active_q;

	logic [FrameBits-1:0] n_bits;
	logic [CountBits-1:0] n_cnt;
	logic [UnitBits-1:0]  n_hu;
	logic                 n_fhl;
	logic                 n_active;
	logic                 emit;
	logic                 done;
	logic [1:0]           st;
	logic [UnitBits-1:0]  len;
	logic [1:0]           units;
	logic                 advance;

	rc6pwd_classify u_classify (
		.width    (width_s1),
		.half_min (half_min),
		.half_max (half_max),
		.units    (units)
	);

	assign advance  = valid_s1 && res_free;
	assign in_ready = !valid_s1 || res_free;

	always_comb begin
		n_bits   = bits_q;
		n_cnt    = cnt_q;
		n_hu     = hu_q;
		n_fhl    = fhl_q;
		n_active = active_q;
		emit     = 1'b0;
		done     = 1'b0;
		st       = ST_OK;
		len      = LEN_NORMAL;
		if (start_s1) begin
			n_bits   = '0;
			n_cnt    = '0;
			n_hu     = '0;
			n_fhl    = 1'b0;
			n_active = 1'b1;
		end
		if (n_active) begin
			if (end_s1) begin
				// A frame end right after the first half of the last bit completes it.
				if (n_cnt == FRAME_LAST_BIT && n_hu == 3'd1) begin
					n_bits = {n_bits[FrameBits-2:0], n_fhl};
					n_cnt  = n_cnt + 5'd1;
					n_hu   = '0;
					st     = ST_OK;
				end else begin
					st = ST_SHORT;
				end
				emit = 1'b1;
			end else if (units == 2'd0) begin
				st   = ST_WIDTH;
				emit = 1'b1;
			end else begin
				for (int k = 0; k < 3; k++) begin
					if (k < int'(units) && !done) begin
						if (n_hu == 3'd0) begin
							n_fhl = level_s1;
						end
						n_hu = n_hu + 3'd1;
						len  = (n_cnt == TRAILER_INDEX) ? LEN_TRAILER : LEN_NORMAL;
						if (n_hu >= len) begin
							n_bits = {n_bits[FrameBits-2:0], n_fhl};
							n_cnt  = n_cnt + 5'd1;
							n_hu   = '0;
							if (n_cnt >= FRAME_TOTAL) begin
								st   = ST_OK;
								emit = 1'b1;
								done = 1'b1;
							end
						end
					end
				end
			end
			if (emit) begin
				n_active = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			bits_q   <= '0;
			cnt_q    <= '0;
			hu_q     <= '0;
			fhl_q    <= 1'b0;
			active_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				bits_q   <= n_bits;
				cnt_q    <= n_cnt;
				hu_q     <= n_hu;
				fhl_q    <= n_fhl;
				active_q <= n_active;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			width_s1 <= in_width;
			level_s1 <= in_level;
			start_s1 <= in_start;
			end_s1   <= in_end;
		end
	end

	always_comb begin
		res_valid = advance && emit;
		if (st == ST_OK) begin
			res.address = n_bits[15:8];
			res.command = n_bits[7:0];
			res.mode    = n_bits[19:17];
			res.toggle  = n_bits[16];
		end else begin
			res.address = '0;
			res.command = '0;
			res.mode    = '0;
			res.toggle  = 1'b0;
		end
		res.status = st;
	end

endmodule

/* hw/rtl/rc6pwd_out_reg.sv */
// ----------------------------------------------------------------------------
// rc6pwd_out_reg
// Result register that holds one decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
module rc6pwd_out_reg
	import rc6pwd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    res_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t data_q;

	assign res_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			data_q <= res;
		end
	end

endmodule

/* hw/rtl/rc6_pulse_width_decoder.sv */
// Path: an accepted pulse passes the input register, then the result register.
// Throughput: one pulse per cycle; the input register and the result register
// each advance when the result register is empty or its request is taken.
// Reset: arst_n clears the frame state and the valid flags at once and loads
// the half-bit window registers with 356 and 534 microseconds.
// ----------------------------------------------------------------------------
// rc6_pulse_width_decoder
// RC6 mode-0 infrared decoder that turns captured pulse widths into frames.
// ----------------------------------------------------------------------------
module rc6_pulse_width_decoder
	import rc6pwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [15:0] pulse_width, [16] pin_level, rest zero
	input  logic        s_tuser,  // [0] frame_start
	input  logic        s_tlast,  // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [7:0] address, [15:8] command, [18:16] mode,
	                              // [19] toggle, [21:20] status, rest zero
);

	logic [WidthBits-1:0] half_min_q;
	logic [WidthBits-1:0] half_max_q;
	logic                 res_valid;
	logic                 res_free;
	result_t              res;
	result_t              out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_min_q <= HALF_MIN_RESET;
			half_max_q <= HALF_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_MIN: half_min_q <= cfg_data;
				CFG_HALF_MAX: half_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rc6pwd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_width  (s_tdata[15:0]),
		.in_level  (s_tdata[16]),
		.in_start  (s_tuser),
		.in_end    (s_tlast),
		.half_min  (half_min_q),
		.half_max  (half_max_q),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res)
	);

	rc6pwd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_free  (res_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {2'b00, out_res.status, out_res.toggle, out_res.mode,
	                  out_res.command, out_res.address};

endmodule
